/* hdl/rbd_pkg.sv */
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int WORD_WIDTH_DEF = 32;

  // Request codes carried in the func field.
  typedef enum logic [3:0] {
    FN_PUSH_BACK  = 4'd0,
    FN_POP_BACK   = 4'd1,
    FN_PUSH_FRONT = 4'd2,
    FN_POP_FRONT  = 4'd3,
    FN_READ_IDX   = 4'd4,
    FN_WRITE_IDX  = 4'd5,
    FN_PEEK_BACK  = 4'd6,
    FN_READ_BACK  = 4'd7,
    FN_CLEAR      = 4'd8
  } rbd_func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } rbd_status_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] value;
    logic [4:0]  index;
  } rbd_in_t;

  typedef struct packed {
    logic [31:0] value_out;
    logic [1:0]  status;
    logic [5:0]  length;
    logic        is_empty;
    logic        is_full;
  } rbd_out_t;

  // Decoded memory action for one request.
  typedef struct packed {
    logic        rd;
    logic        wr;
    logic        wr_zero;
    logic        clr;
    rbd_status_t status;
  } rbd_op_t;

endpackage

/* hdl/rbd_ram.sv */
`timescale 1ns / 1ps

module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/rbd_ptr.sv */
`timescale 1ns / 1ps

module rbd_ptr
  import rbd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       commit,
  input  logic [3:0]                 func,
  input  logic [4:0]                 index,
  output logic [$clog2(DEPTH)-1:0]   slot,
  output rbd_op_t                    op,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int IW = (CW > 6) ? CW : 6;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [IW-1:0] DEPTH_I = IW'(DEPTH);

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] front_w, cnt_w, idx_w;
  logic [IW-1:0] sum_w;
  logic          full, empty;

  assign front_w = IW'(front_r);
  assign cnt_w   = IW'(count_r);
  assign idx_w   = IW'(index);
  assign full    = (count_r == DEPTH_C);
  assign empty   = (count_r == '0);

  always_comb begin
    op        = '{rd: 1'b0, wr: 1'b0, wr_zero: 1'b0, clr: 1'b0, status: STAT_OK};
    front_nxt = front_r;
    count_nxt = count_r;
    sum_w     = front_w;
    case (func)
      FN_PUSH_BACK: begin
        if (full) begin
          op.status = STAT_FULL;
        end else begin
          op.wr     = 1'b1;
          sum_w     = front_w + cnt_w;
          count_nxt = count_r + 1'b1;
        end
      end
      FN_POP_BACK: begin
        if (empty) begin
          op.status = STAT_EMPTY;
        end else begin
          op.rd      = 1'b1;
          op.wr      = 1'b1;
          op.wr_zero = 1'b1;
          sum_w      = front_w + cnt_w - 1'b1;
          count_nxt  = count_r - 1'b1;
        end
      end
      FN_PUSH_FRONT: begin
        if (full) begin
          op.status = STAT_FULL;
        end else begin
          op.wr     = 1'b1;
          sum_w     = front_w - 1'b1;
          front_nxt = front_r - 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      FN_POP_FRONT: begin
        if (empty) begin
          op.status = STAT_EMPTY;
        end else begin
          op.rd      = 1'b1;
          op.wr      = 1'b1;
          op.wr_zero = 1'b1;
          front_nxt  = front_r + 1'b1;
          count_nxt  = count_r - 1'b1;
        end
      end
      FN_READ_IDX: begin
        if (idx_w >= cnt_w) begin
          op.status = STAT_RANGE;
        end else begin
          op.rd = 1'b1;
          sum_w = front_w + idx_w;
        end
      end
      FN_WRITE_IDX: begin
        if (idx_w >= DEPTH_I) begin
          op.status = STAT_RANGE;
        end else begin
          op.wr = 1'b1;
          sum_w = front_w + idx_w;
          // Writing past the back extends the live range; the gap already holds zero.
          if (idx_w >= cnt_w) begin
            count_nxt = CW'(idx_w + 1'b1);
          end
        end
      end
      FN_PEEK_BACK: begin
        if (empty) begin
          op.status = STAT_EMPTY;
        end else begin
          op.rd = 1'b1;
          sum_w = front_w + cnt_w - 1'b1;
        end
      end
      FN_READ_BACK: begin
        if (idx_w >= cnt_w) begin
          op.status = STAT_RANGE;
        end else begin
          op.rd = 1'b1;
          sum_w = front_w + cnt_w - 1'b1 - idx_w;
        end
      end
      FN_CLEAR: begin
        op.clr    = 1'b1;
        front_nxt = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign slot  = sum_w[AW-1:0];
  assign count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (commit) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* hdl/ring_buffer_deque.sv */
`timescale 1ns / 1ps

// Double-ended ring store of DEPTH words of WORD_WIDTH bits. A request is
// taken at a clock edge where start is high and busy is low; its single
// result item appears on out_item for exactly one cycle with out_valid high,
// registered at the end of the execute state that follows acceptance; the
// receiver cannot hold it off. Busy stays high in the execute state, so a new
// request is taken only once the last is through: the accepting cycle reads
// the one slot it touches from the synchronous store, the execute state writes
// that slot back if the request changes it (the pushed or written word, or
// zero for a pop) and registers the result. A clear, and the reset itself,
// sweeps the store to zero one slot per cycle with busy high until the sweep
// ends; the clear's result item is delivered at the end of its sweep and
// reset produces no result. Slots outside the live range always hold zero,
// which is why a write past the back end leaves a gap that reads zero.
module ring_buffer_deque
  import rbd_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rbd_in_t  in_item,
  output logic     out_valid,
  output rbd_out_t out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int IW = (CW > 6) ? CW : 6;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                state_r;
  logic [AW-1:0]         clr_addr_r;
  logic                  clr_report_r;
  rbd_op_t               op_r;
  logic [AW-1:0]         slot_r;
  logic [WORD_WIDTH-1:0] word_r;
  logic                  out_valid_r;
  rbd_out_t              out_item_r;

  logic                  accept;
  rbd_op_t               op;
  logic [AW-1:0]         slot;
  logic [CW-1:0]         count;
  logic [IW-1:0]         count_w;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WORD_WIDTH-1:0] ram_wdata;
  logic [WORD_WIDTH-1:0] ram_rdata;

  // Width adaptation between the fixed 32-bit fields and the stored word.
  logic [WORD_WIDTH+31:0] in_ext;
  logic [WORD_WIDTH+31:0] rd_ext;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign in_ext  = {{WORD_WIDTH{1'b0}}, in_item.value};
  assign rd_ext  = {32'd0, ram_rdata};
  assign count_w = IW'(count);

  rbd_ptr #(
    .DEPTH (DEPTH)
  ) u_ptr (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (accept),
    .func   (in_item.func),
    .index  (in_item.index),
    .slot   (slot),
    .op     (op),
    .count  (count)
  );

  // The sweep owns the write port while clearing; otherwise the execute state
  // of a request writes its slot back when the request changes it.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_r;
    ram_wdata = op_r.wr_zero ? '0 : word_r;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      S_EXEC: begin
        ram_we = op_r.wr;
      end
      default: begin
      end
    endcase
  end

  rbd_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r   <= op;
            slot_r <= slot;
            word_r <= in_ext[WORD_WIDTH-1:0];
            if (op.clr) begin
              state_r      <= S_CLEAR;
              clr_addr_r   <= '0;
              clr_report_r <= 1'b1;
            end else begin
              state_r <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          // Pointers were already updated at accept, so count is the new length.
          out_valid_r          <= 1'b1;
          out_item_r.value_out <= op_r.rd ? rd_ext[31:0] : 32'd0;
          out_item_r.status    <= op_r.status;
          out_item_r.length    <= count_w[5:0];
          out_item_r.is_empty  <= (count == '0);
          out_item_r.is_full   <= (count == DEPTH_C);
          state_r              <= S_IDLE;
        end
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == {AW{1'b1}}) begin
            state_r      <= S_IDLE;
            clr_report_r <= 1'b0;
            if (clr_report_r) begin
              out_valid_r          <= 1'b1;
              out_item_r.value_out <= 32'd0;
              out_item_r.status    <= STAT_OK;
              out_item_r.length    <= 6'd0;
              out_item_r.is_empty  <= 1'b1;
              out_item_r.is_full   <= 1'b0;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* hdl/rbd_checker.sv */
`timescale 1ns / 1ps

module rbd_checker
  import rbd_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input rbd_in_t  in_item,
  input logic     out_valid,
  input rbd_out_t out_item
);

  // Every accepted request other than clear is answered with a result strobe.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.func != FN_CLEAR) |-> ##2 out_valid)
    else $error("request not answered two cycles after acceptance");

  // A result strobe lasts a single cycle.
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // The block is still busy in the cycle after it accepts a request.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after acceptance");

  // Failed requests never return data.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != STAT_OK) |-> (out_item.value_out == 32'd0))
    else $error("failed request returned data");

  // An empty store reports a zero length and is never full.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.is_empty) |-> (out_item.length == 6'd0 && !out_item.is_full))
    else $error("empty flag disagrees with length");

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (.*);

/* bench/ring_buffer_deque_test.sv */
`timescale 1ns / 1ps

module ring_buffer_deque_test;
  import rbd_pkg::*;

  localparam int RING_DEPTH  = DEPTH_DEF;
  // Room for a clear sweep, a full pipeline and some margin at the end.
  localparam int SETTLE      = RING_DEPTH + 8;
  // Well above the slowest correct run, so only a hang reaches it.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1800;
  // Idling stops after this many random items so the tail runs back to back.
  localparam int IDLE_CUTOFF  = 1500;

  // Biases for the random part: fill the store, drain it, or mix everything.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_ANY
  } mix_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  rbd_in_t  in_item = '0;
  logic     out_valid;
  rbd_out_t out_item;

  ring_buffer_deque uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Items waiting to be sent. Each carries the number of idle cycles the sender
  // leaves before it, and a flag that makes the sender wait until every
  // outstanding result has come back.
  rbd_in_t  pending_req[$];
  int       pending_gap[$];
  bit       pending_drain[$];

  // Results predicted for accepted items, oldest first.
  rbd_out_t due_results[$];

  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_full_seen = 0;
  int n_empty_seen = 0;
  int n_range_seen = 0;
  int cycle_count = 0;
  int hold_off = 0;

  // Our own copy of the store: the words, the ring position of the front entry
  // and the number of live entries.
  logic [31:0] ring_word [RING_DEPTH];
  logic [4:0]  ring_front;
  logic [5:0]  ring_count;

  // Applies one request to the copy of the store and returns the result item
  // the block must produce for it. Slots outside the live range are kept at
  // zero, so a write past the back end leaves a gap that reads zero.
  function automatic rbd_out_t next_deque_result(rbd_in_t req);
    rbd_out_t   res;
    logic [4:0] slot;
    res = '0;
    case (req.func)
      FN_PUSH_BACK: begin
        if (ring_count >= 6'(RING_DEPTH)) begin
          res.status = STAT_FULL;
        end else begin
          slot = ring_front + ring_count[4:0];
          ring_word[slot] = req.value;
          ring_count = ring_count + 6'd1;
        end
      end
      FN_POP_BACK: begin
        if (ring_count == 6'd0) begin
          res.status = STAT_EMPTY;
        end else begin
          ring_count = ring_count - 6'd1;
          slot = ring_front + ring_count[4:0];
          res.value_out = ring_word[slot];
          ring_word[slot] = '0;
        end
      end
      FN_PUSH_FRONT: begin
        if (ring_count >= 6'(RING_DEPTH)) begin
          res.status = STAT_FULL;
        end else begin
          ring_front = ring_front - 5'd1;
          ring_word[ring_front] = req.value;
          ring_count = ring_count + 6'd1;
        end
      end
      FN_POP_FRONT: begin
        if (ring_count == 6'd0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.value_out = ring_word[ring_front];
          ring_word[ring_front] = '0;
          ring_front = ring_front + 5'd1;
          ring_count = ring_count - 6'd1;
        end
      end
      FN_READ_IDX: begin
        if ({1'b0, req.index} >= ring_count) begin
          res.status = STAT_RANGE;
        end else begin
          slot = ring_front + req.index;
          res.value_out = ring_word[slot];
        end
      end
      FN_WRITE_IDX: begin
        if (32'(req.index) >= RING_DEPTH) begin
          res.status = STAT_RANGE;
        end else begin
          slot = ring_front + req.index;
          ring_word[slot] = req.value;
          if ({1'b0, req.index} >= ring_count) begin
            ring_count = {1'b0, req.index} + 6'd1;
          end
        end
      end
      FN_PEEK_BACK: begin
        if (ring_count == 6'd0) begin
          res.status = STAT_EMPTY;
        end else begin
          slot = ring_front + ring_count[4:0] - 5'd1;
          res.value_out = ring_word[slot];
        end
      end
      FN_READ_BACK: begin
        if ({1'b0, req.index} >= ring_count) begin
          res.status = STAT_RANGE;
        end else begin
          slot = ring_front + ring_count[4:0] - 5'd1 - req.index;
          res.value_out = ring_word[slot];
        end
      end
      FN_CLEAR: begin
        foreach (ring_word[k]) ring_word[k] = '0;
        ring_front = '0;
        ring_count = '0;
      end
      default: begin
        // The unused codes leave everything alone and report ok.
      end
    endcase
    res.length   = ring_count;
    res.is_empty = (ring_count == 6'd0);
    res.is_full  = (ring_count == 6'(RING_DEPTH));
    return res;
  endfunction

  function automatic rbd_in_t make_req(logic [3:0] func, logic [31:0] value,
                                       logic [4:0] index);
    rbd_in_t r;
    r.func  = func;
    r.value = value;
    r.index = index;
    return r;
  endfunction

  // Words lean on the two extremes now and then, otherwise fully random.
  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic rbd_in_t random_request(mix_t mix);
    rbd_in_t r;
    int      roll;
    r.value = random_word();
    // Half of the positions are kept small so that reads mostly land inside
    // the live range even when the store is only partly filled.
    if ($urandom_range(0, 1) == 0) begin
      r.index = 5'($urandom_range(0, 7));
    end else begin
      r.index = 5'($urandom_range(0, 31));
    end
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 40)      r.func = FN_PUSH_BACK;
        else if (roll < 65) r.func = FN_PUSH_FRONT;
        else if (roll < 72) r.func = FN_WRITE_IDX;
        else if (roll < 80) r.func = FN_READ_IDX;
        else if (roll < 88) r.func = FN_READ_BACK;
        else if (roll < 92) r.func = FN_PEEK_BACK;
        else if (roll < 96) r.func = FN_POP_BACK;
        else                r.func = FN_POP_FRONT;
      end
      MIX_DRAIN: begin
        if (roll < 35)      r.func = FN_POP_BACK;
        else if (roll < 65) r.func = FN_POP_FRONT;
        else if (roll < 75) r.func = FN_READ_IDX;
        else if (roll < 83) r.func = FN_READ_BACK;
        else if (roll < 90) r.func = FN_PEEK_BACK;
        else if (roll < 95) r.func = FN_PUSH_BACK;
        else                r.func = FN_PUSH_FRONT;
      end
      default: begin
        if (roll < 2)      r.func = FN_CLEAR;
        else if (roll < 4) r.func = 4'($urandom_range(9, 15));
        else               r.func = 4'($urandom_range(0, 7));
      end
    endcase
    return r;
  endfunction

  task automatic queue_item(rbd_in_t r, int gap, bit drain);
    pending_req.push_back(r);
    pending_gap.push_back(gap);
    pending_drain.push_back(drain);
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      n_errors++;
    end
  endtask

  // Driver. An item is taken at an edge where start is high and busy is low;
  // its result is predicted right there, from the item still on the port.
  // start is assigned once per edge, so an item that follows straight on
  // keeps start high without a glitch.
  always @(posedge clk) begin : driver
    bit presenting;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      presenting = start;
      if (start && !busy) begin
        due_results.push_back(next_deque_result(in_item));
        n_accepted++;
        presenting = 1'b0;
      end
      if (!presenting && pending_req.size() > 0) begin
        if (hold_off > 0) begin
          hold_off--;
        end else if (pending_gap[0] > 0) begin
          // This cycle is the first of the idle burst.
          hold_off = pending_gap[0] - 1;
          pending_gap[0] = 0;
        end else if (!pending_drain[0] || n_checked == n_accepted) begin
          in_item <= pending_req.pop_front();
          void'(pending_gap.pop_front());
          void'(pending_drain.pop_front());
          presenting = 1'b1;
        end
      end
      start <= presenting;
    end
  end

  // Monitor. Results cannot be held off, so every strobe is checked at once
  // against the oldest prediction. n_checked is updated with a nonblocking
  // assignment so the driver always sees the count from before the edge.
  always @(posedge clk) begin : monitor
    rbd_out_t want;
    if (rst_n && out_valid) begin
      if (out_item.status == STAT_FULL) n_full_seen++;
      if (out_item.status == STAT_EMPTY) n_empty_seen++;
      if (out_item.status == STAT_RANGE) n_range_seen++;
      if (due_results.size() == 0) begin
        $display("%0t ns: result with no item outstanding, expected none, actual %0h",
                 $time, out_item);
        n_errors++;
      end else begin
        want = due_results.pop_front();
        check_field("value_out", want.value_out, out_item.value_out);
        check_field("status", 32'(want.status), 32'(out_item.status));
        check_field("length", 32'(want.length), 32'(out_item.length));
        check_field("is_empty", 32'(want.is_empty), 32'(out_item.is_empty));
        check_field("is_full", 32'(want.is_full), 32'(out_item.is_full));
        n_checked <= n_checked + 1;
      end
    end
  end

  // A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    mix_t mix;
    bit   idle_on;
    int   seg_left;
    int   gap;
    ring_front = '0;
    ring_count = '0;
    foreach (ring_word[k]) ring_word[k] = '0;

    // Directed part. Everything on an empty store first: pops, peek and both
    // reads must report empty or out of range.
    queue_item(make_req(FN_READ_IDX, '1, 5'd0), 0, 1'b0);
    queue_item(make_req(FN_POP_BACK, '1, 5'd31), 0, 1'b0);
    queue_item(make_req(FN_POP_FRONT, '0, 5'd0), 1, 1'b0);
    queue_item(make_req(FN_PEEK_BACK, '0, 5'd0), 0, 1'b0);
    queue_item(make_req(FN_READ_BACK, '0, 5'd0), 3, 1'b0);
    // A few entries at both ends, then reads from either side.
    queue_item(make_req(FN_PUSH_BACK, 32'hFFFF_FFFF, 5'd31), 0, 1'b0);
    queue_item(make_req(FN_PUSH_FRONT, 32'h0000_0000, 5'd0), 0, 1'b0);
    queue_item(make_req(FN_PUSH_BACK, 32'hA5A5_A5A5, 5'd0), 2, 1'b0);
    queue_item(make_req(FN_READ_IDX, '0, 5'd0), 0, 1'b0);
    queue_item(make_req(FN_READ_IDX, '0, 5'd2), 0, 1'b0);
    queue_item(make_req(FN_READ_IDX, '0, 5'd31), 0, 1'b0);
    queue_item(make_req(FN_READ_BACK, '0, 5'd0), 0, 1'b0);
    queue_item(make_req(FN_READ_BACK, '0, 5'd1), 0, 1'b0);
    queue_item(make_req(FN_PEEK_BACK, '0, 5'd0), 0, 1'b0);
    // A write at the last position extends the back end to a full store and
    // leaves a gap that must read zero; pushes on the full store are refused.
    queue_item(make_req(FN_WRITE_IDX, 32'hFFFF_FFFF, 5'd31), 0, 1'b1);
    queue_item(make_req(FN_READ_IDX, '1, 5'd10), 0, 1'b0);
    queue_item(make_req(FN_PUSH_BACK, 32'h1234_5678, 5'd0), 0, 1'b0);
    queue_item(make_req(FN_PUSH_FRONT, 32'h8765_4321, 5'd0), 0, 1'b0);
    queue_item(make_req(FN_READ_BACK, '0, 5'd31), 0, 1'b0);
    queue_item(make_req(FN_POP_FRONT, '0, 5'd0), 0, 1'b0);
    queue_item(make_req(FN_POP_BACK, '0, 5'd0), 0, 1'b0);
    // Unused codes at the low and high end of their range.
    queue_item(make_req(4'd9, '1, 5'd31), 0, 1'b0);
    queue_item(make_req(4'd15, '1, 5'd31), 0, 1'b0);
    // Clear, then a pop on the emptied store and a write that starts afresh.
    queue_item(make_req(FN_CLEAR, '1, 5'd31), 0, 1'b0);
    queue_item(make_req(FN_POP_BACK, '0, 5'd0), 0, 1'b0);
    queue_item(make_req(FN_WRITE_IDX, 32'h5A5A_5A5A, 5'd0), 0, 1'b0);

    // Random part, in segments that each lean toward filling, draining or a
    // mix. Idle bursts come only in some segments, and not in the tail. Now
    // and then the sender waits for every outstanding result first.
    seg_left = 0;
    mix = MIX_ANY;
    idle_on = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 80);
        mix = mix_t'($urandom_range(0, 2));
        idle_on = ($urandom_range(0, 2) != 0);
      end
      seg_left--;
      gap = 0;
      if (idle_on && n < IDLE_CUTOFF && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 8);
      end
      queue_item(random_request(mix), gap, (n % 250) == 249);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every item has been taken, then until every result is back,
    // then a little longer so a stray late result would still be caught.
    while (pending_req.size() > 0 || start) @(negedge clk);
    while (n_checked != n_accepted) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    if (due_results.size() != 0) begin
      $display("%0t ns: results outstanding, expected 0, actual %0d",
               $time, due_results.size());
      n_errors++;
    end

    $display("Sent %0d items and checked %0d results in %0d cycles.",
             n_accepted, n_checked, cycle_count);
    $display("Refusals seen: %0d full, %0d empty, %0d out of range; %0d errors.",
             n_full_seen, n_empty_seen, n_range_seen, n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
